// ===== design/crlb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Connection rate limiter package
// Shared table depths, reset values, verdict codes, register indices and item kinds.
// ---------------------------------------------------------------------------
package crlb_pkg;
    localparam int COUNT_ENTRIES_DEF = 64;
    localparam int BAN_ENTRIES_DEF   = 64;

    localparam logic [15:0] LIMIT_RST  = 16'd100;
    localparam logic [15:0] WINDOW_RST = 16'd60;
    localparam logic [15:0] BAN_RST    = 16'd600;

    localparam logic [2:0] VERDICT_ACCEPT     = 3'd0;
    localparam logic [2:0] VERDICT_BANNED     = 3'd1;
    localparam logic [2:0] VERDICT_NEW_BAN    = 3'd2;
    localparam logic [2:0] VERDICT_COUNT_FULL = 3'd3;
    localparam logic [2:0] VERDICT_BAN_FULL   = 3'd4;

    localparam logic [1:0] REG_LIMIT  = 2'd0;
    localparam logic [1:0] REG_WINDOW = 2'd1;
    localparam logic [1:0] REG_BAN    = 2'd2;

    localparam logic KIND_CONNECT = 1'b0;
    localparam logic KIND_TICK    = 1'b1;
endpackage

// ===== design/connection_rate_limiter_with_ban_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Connection rate limiter with ban
// Per-source fixed-window connection limiter with a temporary ban table.
// ---------------------------------------------------------------------------
// A connect scans the ban memory, then the count memory, one entry per cycle,
// then decides and strobes its result. A tick that rolls the window reaps the
// ban memory the same way before its result; any other tick goes straight to it.
// One item at a time; busy drops in the strobe cycle, so the next word can be
// taken there. Reset clears all valid bits at once; memory contents need no
// clearing. The receiver cannot stall results.
module connection_rate_limiter_with_ban_core
    import crlb_pkg::*;
#(
    parameter int COUNT_ENTRIES = COUNT_ENTRIES_DEF,
    parameter int BAN_ENTRIES   = BAN_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [31:0] src_addr,
    input  logic [31:0] now_seconds,
    output logic        done,
    output logic [2:0]  verdict,
    output logic [16:0] attempt_count,
    output logic        window_rolled,
    output logic [6:0]  bans_reaped
);
    localparam int CW = $clog2(COUNT_ENTRIES);
    localparam int BW = $clog2(BAN_ENTRIES);
    localparam logic [CW:0] CLAST = (CW + 1)'(COUNT_ENTRIES - 1);
    localparam logic [BW:0] BLAST = (BW + 1)'(BAN_ENTRIES - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BSCAN = 3'd1;
    localparam logic [2:0] ST_CSCAN = 3'd2;
    localparam logic [2:0] ST_DEC   = 3'd3;
    localparam logic [2:0] ST_REAP  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // Memories: addresses and values, with registered (synchronous) reads.
    logic [31:0] cmem_addr [COUNT_ENTRIES];
    logic [16:0] cmem_val  [COUNT_ENTRIES];
    logic [31:0] bmem_addr [BAN_ENTRIES];
    logic [31:0] bmem_exp  [BAN_ENTRIES];
    logic [COUNT_ENTRIES-1:0] cvalid_reg;
    logic [BAN_ENTRIES-1:0]   bvalid_reg;

    logic [15:0] limit_reg, window_reg, bansec_reg;
    logic [31:0] wstart_reg;
    logic [2:0]  state_reg;
    logic [CW:0] cidx_reg;
    logic [BW:0] bidx_reg;
    logic        rd_pend_reg;
    logic [CW-1:0] crd_idx_reg;
    logic [BW-1:0] brd_idx_reg;
    logic [31:0] crd_addr_reg, brd_addr_reg, brd_exp_reg;
    logic [16:0] crd_val_reg;
    logic        kind_reg;
    logic [31:0] addr_reg, now_reg;
    logic        bhit_reg, chit_reg;
    logic [BW-1:0] bhit_idx_reg;
    logic [31:0] bhit_exp_reg;
    logic [CW-1:0] chit_idx_reg;
    logic [16:0] chit_val_reg;
    logic [6:0]  reaped_reg;

    // Configuration port.
    logic wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    always_comb
    begin
        unique case (paddr[3:2])
            REG_LIMIT:  prdata = {16'd0, limit_reg};
            REG_WINDOW: prdata = {16'd0, window_reg};
            REG_BAN:    prdata = {16'd0, bansec_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RST;
            window_reg <= WINDOW_RST;
            bansec_reg <= BAN_RST;
        end
        else if (wr_en && paddr[1:0] == 2'd0)
        begin
            if (paddr[3:2] == REG_LIMIT)  limit_reg  <= pwdata[15:0];
            if (paddr[3:2] == REG_WINDOW) window_reg <= pwdata[15:0];
            if (paddr[3:2] == REG_BAN)    bansec_reg <= pwdata[15:0];
        end
    end

    // Lowest free slots, found over the valid flops; a ban hit's own slot counts as free.
    logic          cfree_ok, bfree_ok;
    logic [CW-1:0] cfree_idx;
    logic [BW-1:0] bfree_idx;
    always_comb
    begin
        cfree_ok  = 1'b0;
        cfree_idx = '0;
        for (int i = COUNT_ENTRIES - 1; i >= 0; i--)
            if (!cvalid_reg[i])
            begin
                cfree_ok  = 1'b1;
                cfree_idx = CW'(i);
            end
        bfree_ok  = 1'b0;
        bfree_idx = '0;
        for (int i = BAN_ENTRIES - 1; i >= 0; i--)
            if (!bvalid_reg[i] || (bhit_reg && BW'(i) == bhit_idx_reg))
            begin
                bfree_ok  = 1'b1;
                bfree_idx = BW'(i);
            end
    end

    // Decision arithmetic.
    logic        banned_now;
    logic [16:0] base_cnt, new_cnt;
    logic [32:0] exp_sum;
    logic [31:0] exp_sat;
    assign banned_now = bhit_reg && (now_reg < bhit_exp_reg);
    assign base_cnt   = chit_reg ? chit_val_reg : 17'd0;
    assign new_cnt    = base_cnt + 17'd1;
    assign exp_sum    = {1'b0, now_reg} + {17'd0, bansec_reg};
    assign exp_sat    = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

    logic roll;
    assign roll = (now_seconds >= wstart_reg) &&
                  ((now_seconds - wstart_reg) >= {16'd0, window_reg});

    assign busy = (state_reg != ST_IDLE);

    // Synchronous memory reads and writes.
    logic          cwe, bwe;
    logic [CW-1:0] cw_idx;
    logic [BW-1:0] bw_idx;
    logic [31:0]   bw_exp;
    logic [16:0]   cw_val;
    always_ff @(posedge clk)
    begin
        crd_addr_reg <= cmem_addr[cidx_reg[CW-1:0]];
        crd_val_reg  <= cmem_val[cidx_reg[CW-1:0]];
        brd_addr_reg <= bmem_addr[bidx_reg[BW-1:0]];
        brd_exp_reg  <= bmem_exp[bidx_reg[BW-1:0]];
        if (cwe)
        begin
            cmem_addr[cw_idx] <= addr_reg;
            cmem_val[cw_idx]  <= cw_val;
        end
        if (bwe)
        begin
            bmem_addr[bw_idx] <= addr_reg;
            bmem_exp[bw_idx]  <= bw_exp;
        end
    end

    always_comb
    begin
        cwe    = 1'b0;
        bwe    = 1'b0;
        cw_idx = chit_reg ? chit_idx_reg : cfree_idx;
        cw_val = new_cnt;
        bw_idx = bfree_idx;
        bw_exp = exp_sat;
        if (state_reg == ST_DEC && kind_reg == KIND_CONNECT && !banned_now)
        begin
            if ({1'b0, limit_reg} < new_cnt)
                bwe = bfree_ok;
            else
                cwe = chit_reg || cfree_ok;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cvalid_reg    <= '0;
            bvalid_reg    <= '0;
            wstart_reg    <= 32'd0;
            done          <= 1'b0;
            rd_pend_reg   <= 1'b0;
            cidx_reg      <= '0;
            bidx_reg      <= '0;
            crd_idx_reg   <= '0;
            brd_idx_reg   <= '0;
            kind_reg      <= KIND_CONNECT;
            addr_reg      <= 32'd0;
            now_reg       <= 32'd0;
            bhit_reg      <= 1'b0;
            chit_reg      <= 1'b0;
            bhit_idx_reg  <= '0;
            bhit_exp_reg  <= 32'd0;
            chit_idx_reg  <= '0;
            chit_val_reg  <= 17'd0;
            reaped_reg    <= 7'd0;
            verdict       <= VERDICT_ACCEPT;
            attempt_count <= 17'd0;
            window_rolled <= 1'b0;
            bans_reaped   <= 7'd0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg   <= kind;
                        addr_reg   <= src_addr;
                        now_reg    <= now_seconds;
                        bhit_reg   <= 1'b0;
                        chit_reg   <= 1'b0;
                        reaped_reg <= 7'd0;
                        cidx_reg   <= '0;
                        bidx_reg   <= '0;
                        rd_pend_reg <= 1'b0;
                        window_rolled <= 1'b0;
                        if (kind == KIND_TICK)
                        begin
                            if (roll)
                            begin
                                cvalid_reg    <= '0;
                                wstart_reg    <= now_seconds;
                                window_rolled <= 1'b1;
                                state_reg     <= ST_REAP;
                            end
                            else
                                state_reg <= ST_OUT;
                        end
                        else
                            state_reg <= ST_BSCAN;
                    end
                end
                ST_BSCAN, ST_REAP:
                begin
                    // Issue one read per cycle, check the previous one.
                    if (rd_pend_reg && bvalid_reg[brd_idx_reg])
                    begin
                        if (state_reg == ST_REAP)
                        begin
                            if (now_reg >= brd_exp_reg)
                            begin
                                bvalid_reg[brd_idx_reg] <= 1'b0;
                                if (reaped_reg != 7'd127)
                                    reaped_reg <= reaped_reg + 7'd1;
                            end
                        end
                        else if (brd_addr_reg == addr_reg && !bhit_reg)
                        begin
                            bhit_reg     <= 1'b1;
                            bhit_idx_reg <= brd_idx_reg;
                            bhit_exp_reg <= brd_exp_reg;
                        end
                    end
                    brd_idx_reg <= bidx_reg[BW-1:0];
                    if (rd_pend_reg && brd_idx_reg == BLAST[BW-1:0])
                    begin
                        rd_pend_reg <= 1'b0;
                        state_reg   <= (state_reg == ST_REAP) ? ST_OUT : ST_CSCAN;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                        if (bidx_reg != BLAST)
                            bidx_reg <= bidx_reg + 1'b1;
                    end
                end
                ST_CSCAN:
                begin
                    if (rd_pend_reg && cvalid_reg[crd_idx_reg] &&
                        crd_addr_reg == addr_reg && !chit_reg)
                    begin
                        chit_reg     <= 1'b1;
                        chit_idx_reg <= crd_idx_reg;
                        chit_val_reg <= crd_val_reg;
                    end
                    crd_idx_reg <= cidx_reg[CW-1:0];
                    if (rd_pend_reg && crd_idx_reg == CLAST[CW-1:0])
                    begin
                        rd_pend_reg <= 1'b0;
                        state_reg   <= ST_DEC;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                        if (cidx_reg != CLAST)
                            cidx_reg <= cidx_reg + 1'b1;
                    end
                end
                ST_DEC:
                begin
                    state_reg <= ST_OUT;
                    if (banned_now)
                    begin
                        verdict       <= VERDICT_BANNED;
                        attempt_count <= base_cnt;
                    end
                    else
                    begin
                        if (bhit_reg)
                            bvalid_reg[bhit_idx_reg] <= 1'b0;
                        attempt_count <= new_cnt;
                        if ({1'b0, limit_reg} < new_cnt)
                        begin
                            if (bfree_ok)
                            begin
                                bvalid_reg[bfree_idx] <= 1'b1;
                                if (chit_reg)
                                    cvalid_reg[chit_idx_reg] <= 1'b0;
                                verdict <= VERDICT_NEW_BAN;
                            end
                            else
                                verdict <= VERDICT_BAN_FULL;
                        end
                        else if (chit_reg)
                            verdict <= VERDICT_ACCEPT;
                        else if (cfree_ok)
                        begin
                            cvalid_reg[cfree_idx] <= 1'b1;
                            verdict <= VERDICT_ACCEPT;
                        end
                        else
                        begin
                            verdict       <= VERDICT_COUNT_FULL;
                            attempt_count <= 17'd0;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (kind_reg == KIND_TICK)
                    begin
                        verdict       <= VERDICT_ACCEPT;
                        attempt_count <= 17'd0;
                    end
                    bans_reaped <= reaped_reg;
                    done        <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== design/crlb_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Connection rate limiter port checker
// Watches the command and result ports of the limiter over time.
// ---------------------------------------------------------------------------
module crlb_checker
    import crlb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  verdict,
    input logic [16:0] attempt_count,
    input logic        window_rolled,
    input logic [6:0]  bans_reaped
);
    // An accepted word makes the block busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");

    // A result word ends the item.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("busy during result");

    // Verdicts stay in range.
    a_verd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> verdict <= VERDICT_BAN_FULL) else $error("bad verdict");

    // Rolled and reaped only appear with a zero verdict.
    a_roll: assert property (@(posedge clk) disable iff (!rst_n)
        done && window_rolled |-> verdict == VERDICT_ACCEPT && attempt_count == 17'd0)
        else $error("roll fields wrong");

    // Reaping only happens on a roll.
    a_reap: assert property (@(posedge clk) disable iff (!rst_n)
        done && !window_rolled |-> bans_reaped == 7'd0) else $error("stray reap");
endmodule

bind connection_rate_limiter_with_ban_core crlb_checker u_crlb_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .verdict(verdict), .attempt_count(attempt_count),
    .window_rolled(window_rolled), .bans_reaped(bans_reaped)
);

// ===== tb/sv/connection_rate_limiter_with_ban_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Connection rate limiter with ban: block-level test
// Drives connect and tick words through the start/busy port, reprograms the
// limit, window and ban registers over APB between phases, and compares each
// result word against a predictor with its own copy of both tables.
// ---------------------------------------------------------------------------
module connection_rate_limiter_with_ban_core_test;
    import crlb_pkg::*;

    localparam int NCOUNT      = COUNT_ENTRIES_DEF;
    localparam int NBAN        = BAN_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [16:0] count;
        logic        rolled;
        logic [6:0]  reaped;
    } outcome_t;

    // Predictor and store of expected result words.
    class rate_limit_board;
        logic [31:0] cnt_addr [NCOUNT];
        logic [16:0] cnt_val  [NCOUNT];
        bit          cnt_vld  [NCOUNT];
        logic [31:0] ban_addr [NBAN];
        logic [31:0] ban_exp  [NBAN];
        bit          ban_vld  [NBAN];
        logic [31:0] win_start;
        logic [15:0] limit_reg;
        logic [15:0] window_reg;
        logic [15:0] ban_reg;
        outcome_t    pending [$];
        int          errors;

        function new();
            foreach (cnt_vld[i]) cnt_vld[i] = 0;
            foreach (ban_vld[i]) ban_vld[i] = 0;
            win_start  = '0;
            limit_reg  = LIMIT_RST;
            window_reg = WINDOW_RST;
            ban_reg    = BAN_RST;
            errors     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            if (idx == REG_LIMIT)
                limit_reg = value;
            else if (idx == REG_WINDOW)
                window_reg = value;
            else if (idx == REG_BAN)
                ban_reg = value;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        // Works out the result word of one accepted input word.
        function void note_item(logic kind, logic [31:0] addr, logic [31:0] now);
            outcome_t     res;
            int           b;
            int           c;
            int           f;
            logic [32:0]  sum;
            int unsigned  newcnt;
            res = '0;
            b = -1;
            c = -1;
            f = -1;
            if (kind == KIND_TICK) begin
                if (now >= win_start && now - win_start >= {16'd0, window_reg}) begin
                    res.rolled = 1'b1;
                    win_start = now;
                    foreach (cnt_vld[i]) cnt_vld[i] = 0;
                    foreach (ban_vld[i]) begin
                        if (ban_vld[i] && now >= ban_exp[i]) begin
                            ban_vld[i] = 0;
                            if (res.reaped < 7'd127)
                                res.reaped++;
                        end
                    end
                end
            end else begin
                for (int i = NBAN - 1; i >= 0; i--)
                    if (ban_vld[i] && ban_addr[i] == addr) b = i;
                for (int i = NCOUNT - 1; i >= 0; i--)
                    if (cnt_vld[i] && cnt_addr[i] == addr) c = i;
                if (b >= 0 && now < ban_exp[b]) begin
                    // Active ban: report the stored count, change nothing.
                    res.verdict = VERDICT_BANNED;
                    res.count = (c >= 0) ? cnt_val[c] : 17'd0;
                end else begin
                    if (b >= 0) ban_vld[b] = 0;
                    newcnt = ((c >= 0) ? cnt_val[c] : 0) + 1;
                    res.count = newcnt[16:0];
                    if (newcnt > limit_reg) begin
                        for (int i = NBAN - 1; i >= 0; i--)
                            if (!ban_vld[i]) f = i;
                        if (f < 0) begin
                            res.verdict = VERDICT_BAN_FULL;
                        end else begin
                            sum = {1'b0, now} + {17'd0, ban_reg};
                            ban_addr[f] = addr;
                            ban_exp[f]  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                            ban_vld[f]  = 1;
                            if (c >= 0) cnt_vld[c] = 0;
                            res.verdict = VERDICT_NEW_BAN;
                        end
                    end else if (c >= 0) begin
                        cnt_val[c] = newcnt[16:0];
                        res.verdict = VERDICT_ACCEPT;
                    end else begin
                        for (int i = NCOUNT - 1; i >= 0; i--)
                            if (!cnt_vld[i]) f = i;
                        if (f < 0) begin
                            res.verdict = VERDICT_COUNT_FULL;
                            res.count = '0;
                        end else begin
                            cnt_addr[f] = addr;
                            cnt_val[f]  = newcnt[16:0];
                            cnt_vld[f]  = 1;
                            res.verdict = VERDICT_ACCEPT;
                        end
                    end
                end
            end
            pending.push_back(res);
        endfunction

        // Compares one result word against the oldest expectation.
        task check_result(outcome_t got);
            outcome_t exp;
            if (pending.size() == 0) begin
                report("result word with no expectation waiting");
            end else begin
                exp = pending.pop_front();
                if (got.verdict !== exp.verdict)
                    report($sformatf("verdict %0d, expected %0d", got.verdict, exp.verdict));
                if (got.count !== exp.count)
                    report($sformatf("attempt_count %0d, expected %0d", got.count, exp.count));
                if (got.rolled !== exp.rolled)
                    report($sformatf("window_rolled %0b, expected %0b", got.rolled, exp.rolled));
                if (got.reaped !== exp.reaped)
                    report($sformatf("bans_reaped %0d, expected %0d", got.reaped, exp.reaped));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        kind;
    logic [31:0] src_addr;
    logic [31:0] now_seconds;
    logic        done;
    logic [2:0]  verdict;
    logic [16:0] attempt_count;
    logic        window_rolled;
    logic [6:0]  bans_reaped;

    rate_limit_board board;
    int          idle_pct;
    logic [31:0] clock_now;
    int          cycles;

    connection_rate_limiter_with_ban_core uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .kind(kind), .src_addr(src_addr),
        .now_seconds(now_seconds), .done(done), .verdict(verdict),
        .attempt_count(attempt_count), .window_rolled(window_rolled),
        .bans_reaped(bans_reaped)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Result monitor: every strobed word is checked at the edge ending it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result({verdict, attempt_count, window_rolled, bans_reaped});
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("connection_rate_limiter_with_ban_core test failed");
            $finish;
        end
    end

    // Register write through a setup and an access cycle; called at a falling edge.
    task write_reg(logic [1:0] idx, logic [15:0] value);
        psel   = 1'b1;
        pwrite = 1'b1;
        paddr  = {idx, 2'b00};
        pwdata = {16'd0, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        board.set_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Waits for every expected word, then lets the block settle.
    task drain();
        start = 1'b0;
        while (board.pending.size() != 0 || busy) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task configure(logic [15:0] lim, logic [15:0] win, logic [15:0] ban);
        drain();
        write_reg(REG_LIMIT, lim);
        write_reg(REG_WINDOW, win);
        write_reg(REG_BAN, ban);
    endtask

    // Optionally idles first, then presents one word and holds it until it is taken; called at a falling edge.
    task send_item(logic k, logic [31:0] addr, logic [31:0] now);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
        start       = 1'b1;
        kind        = k;
        src_addr    = addr;
        now_seconds = now;
        do @(posedge clk); while (busy);
        board.note_item(k, addr, now);
        @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] pool [6];
        logic [31:0] addr;
        logic [31:0] now;
        int          pick;
        board = new();
        cycles = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        kind = KIND_CONNECT;
        src_addr = '0;
        now_seconds = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under reset settings first.
        send_item(KIND_TICK, 32'h0, 32'd0);
        send_item(KIND_TICK, 32'h0, 32'd60);
        send_item(KIND_CONNECT, 32'h0000_0000, 32'd61);
        send_item(KIND_CONNECT, 32'hFFFF_FFFF, 32'd62);
        send_item(KIND_CONNECT, 32'hFFFF_FFFF, 32'd63);
        configure(16'd1, 16'd60, 16'd5);
        send_item(KIND_CONNECT, 32'h0A00_0001, 32'd100);
        send_item(KIND_CONNECT, 32'h0A00_0001, 32'd101);
        send_item(KIND_CONNECT, 32'h0A00_0001, 32'd102);
        // Expired ban is deleted and the attempt counts afresh.
        send_item(KIND_CONNECT, 32'h0A00_0001, 32'd106);
        send_item(KIND_CONNECT, 32'h0A00_0002, 32'd107);
        send_item(KIND_CONNECT, 32'h0A00_0002, 32'd108);
        send_item(KIND_TICK, 32'hFFFF_FFFF, 32'd200);
        // Zero limit bans on the first attempt; large ban saturates expiry.
        configure(16'd0, 16'd0, 16'd65535);
        send_item(KIND_CONNECT, 32'hC0A8_0001, 32'd201);
        send_item(KIND_CONNECT, 32'hC0A8_0002, 32'hFFFF_FFF0);
        send_item(KIND_CONNECT, 32'hC0A8_0002, 32'hFFFF_FFFE);
        // Time going backwards does not roll; zero window rolls every tick.
        send_item(KIND_TICK, 32'h0, 32'd5);
        send_item(KIND_TICK, 32'h0, 32'd200);
        send_item(KIND_TICK, 32'h0, 32'd200);
        configure(16'd65535, 16'd65535, 16'd1);
        send_item(KIND_CONNECT, 32'h5555_AAAA, 32'd300);
        send_item(KIND_TICK, 32'h0, 32'd400);

        // Random part: small address pool mostly, a wide range to fill tables.
        foreach (pool[i]) pool[i] = $urandom;
        clock_now = 32'd1000;
        for (int n = 0; n < 450; n++) begin
            if (n % 75 == 0) begin
                case ((n / 75) % 6)
                    0: configure(16'd3, 16'd20, 16'd40);
                    1: configure(16'd1, 16'd400, 16'd65535);
                    2: configure(16'd2, 16'd0, 16'd10);
                    3: configure(16'd65535, 16'd1, 16'd1);
                    4: configure(16'd1, 16'd65535, 16'd65535);
                    default: configure(16'd4, 16'd30, 16'd100);
                endcase
                case ((n / 75) % 4)
                    0: idle_pct = 0;
                    1: idle_pct = 72;
                    2: idle_pct = 0;
                    default: idle_pct = 28;
                endcase
            end
            clock_now = clock_now + $urandom_range(0, 4);
            if ($urandom_range(99) < 15) begin
                now = ($urandom_range(9) == 0) ? clock_now - $urandom_range(1, 50)
                                               : clock_now;
                send_item(KIND_TICK, $urandom, now);
            end else begin
                pick = $urandom_range(99);
                if (pick < 65)
                    addr = pool[$urandom_range(5)];
                else if (pick < 92)
                    addr = 32'h0B00_0000 + $urandom_range(0, 79);
                else
                    addr = $urandom;
                now = ($urandom_range(19) == 0) ? $urandom : clock_now;
                send_item(KIND_CONNECT, addr, now);
            end
        end

        drain();
        repeat (200) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("connection_rate_limiter_with_ban_core test passed");
        else
            $display("connection_rate_limiter_with_ban_core test failed");
        $finish;
    end
endmodule
